// ----- hdl/esf_pkg.sv -----
package esf_pkg;

	localparam int SIDE = 64;
	localparam int IDX_W = $clog2(SIDE);

	typedef logic [SIDE-1:0] line_t;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_LOAD,
		CMD_SEED,
		CMD_COL_FWD,
		CMD_COL_BWD,
		CMD_ROW_BWD,
		CMD_ROW_FWD,
		CMD_EMIT
	} cmd_t;

	typedef struct packed {
		cmd_t op;
	} ctl_t;

	function automatic line_t rev_line(input line_t v);
		line_t r;
		for (int i = 0; i < SIDE; i++) begin
			r[i] = v[SIDE-1-i];
		end
		return r;
	endfunction

	// spread each seed towards higher indices through its free run
	function automatic line_t fill_up(input line_t f, input line_t s);
		line_t sum;
		sum = f + s;
		return f & ((sum ^ f) | s);
	endfunction

	function automatic line_t line_fill(input line_t f, input line_t cur, input line_t prev);
		line_t s;
		line_t up;
		line_t dn;
		s = f & (cur | prev | (prev << 1) | (prev >> 1));
		up = fill_up(f, s);
		dn = rev_line(fill_up(rev_line(f), rev_line(s)));
		return up | dn;
	endfunction

endpackage

// ----- hdl/esf_ctrl.sv -----
module esf_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	output esf_pkg::ctl_t               ctl,
	output logic                        result_valid,
	output logic [esf_pkg::IDX_W-1:0]   row_number,
	output logic                        last_row
);

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_SEED = 3'd1;
	localparam logic [2:0] ST_COLF = 3'd2;
	localparam logic [2:0] ST_COLB = 3'd3;
	localparam logic [2:0] ST_ROWB = 3'd4;
	localparam logic [2:0] ST_ROWF = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	localparam logic [esf_pkg::IDX_W-1:0] LAST_IDX = esf_pkg::IDX_W'(esf_pkg::SIDE - 1);
	localparam logic [esf_pkg::IDX_W-1:0] WAVE_END = esf_pkg::IDX_W'(esf_pkg::SIDE - 2);

	logic [2:0]                  state_q;
	logic [2:0]                  state_d;
	logic [esf_pkg::IDX_W-1:0]   cnt_q;
	logic [esf_pkg::IDX_W-1:0]   cnt_d;
	logic                        accept;

	assign busy = (state_q != ST_LOAD);
	assign accept = start && !busy;
	assign result_valid = (state_q == ST_EMIT);
	assign row_number = cnt_q;
	assign last_row = result_valid && (cnt_q == LAST_IDX);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		ctl.op = esf_pkg::CMD_HOLD;
		unique case (state_q)
			ST_LOAD: begin
				if (accept) begin
					ctl.op = esf_pkg::CMD_LOAD;
					cnt_d = cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						state_d = ST_SEED;
						cnt_d = '0;
					end
				end
			end
			ST_SEED: begin
				ctl.op = esf_pkg::CMD_SEED;
				state_d = ST_COLF;
			end
			ST_COLF, ST_COLB, ST_ROWB, ST_ROWF: begin
				unique case (state_q)
					ST_COLF: ctl.op = esf_pkg::CMD_COL_FWD;
					ST_COLB: ctl.op = esf_pkg::CMD_COL_BWD;
					ST_ROWB: ctl.op = esf_pkg::CMD_ROW_BWD;
					default: ctl.op = esf_pkg::CMD_ROW_FWD;
				endcase
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == WAVE_END) begin
					cnt_d = '0;
					state_d = state_q + 3'd1;
				end
			end
			ST_EMIT: begin
				ctl.op = esf_pkg::CMD_EMIT;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST_IDX) begin
					cnt_d = '0;
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
				cnt_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

// ----- hdl/esf_datapath.sv -----
module esf_datapath (
	input  logic                      clk,
	input  esf_pkg::ctl_t             ctl,
	input  logic [esf_pkg::SIDE-1:0]  occupied_row,
	output logic [esf_pkg::SIDE-1:0]  enclosed_row
);

	localparam int S = esf_pkg::SIDE;
	localparam logic [S-1:0] EDGE = {1'b1, {(S-2){1'b0}}, 1'b1};

	// wall and reach rows, rotated in place so the working line sits at fixed taps
	logic [S-1:0] w_q [S];
	logic [S-1:0] r_q [S];

	esf_pkg::line_t fr;
	esf_pkg::line_t cu;
	esf_pkg::line_t pv;
	esf_pkg::line_t nl;

	always_comb begin
		fr = '0;
		cu = '0;
		pv = '0;
		unique case (ctl.op)
			esf_pkg::CMD_COL_FWD: begin
				for (int k = 0; k < S; k++) begin
					fr[k] = ~w_q[k][1];
					cu[k] = r_q[k][1];
					pv[k] = r_q[k][0];
				end
			end
			esf_pkg::CMD_COL_BWD: begin
				for (int k = 0; k < S; k++) begin
					fr[k] = ~w_q[k][S-1];
					cu[k] = r_q[k][S-1];
					pv[k] = r_q[k][0];
				end
			end
			esf_pkg::CMD_ROW_BWD: begin
				fr = ~w_q[S-2];
				cu = r_q[S-2];
				pv = r_q[S-1];
			end
			esf_pkg::CMD_ROW_FWD: begin
				fr = ~w_q[0];
				cu = r_q[0];
				pv = r_q[S-1];
			end
			default: begin
				fr = '0;
			end
		endcase
		nl = esf_pkg::line_fill(fr, cu, pv);
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			esf_pkg::CMD_HOLD: begin
			end
			esf_pkg::CMD_LOAD, esf_pkg::CMD_EMIT: begin
				for (int k = 0; k < S-1; k++) begin
					w_q[k] <= w_q[k+1];
					r_q[k] <= r_q[k+1];
				end
				w_q[S-1] <= occupied_row;
				r_q[S-1] <= r_q[0];
			end
			esf_pkg::CMD_SEED: begin
				for (int k = 0; k < S; k++) begin
					r_q[k] <= ~w_q[k] & ((k == 0 || k == S-1) ? {S{1'b1}} : EDGE);
				end
			end
			esf_pkg::CMD_COL_FWD: begin
				for (int k = 0; k < S; k++) begin
					w_q[k] <= {w_q[k][0], w_q[k][S-1:1]};
					r_q[k] <= {r_q[k][0], r_q[k][S-1:2], nl[k]};
				end
			end
			esf_pkg::CMD_COL_BWD: begin
				for (int k = 0; k < S; k++) begin
					w_q[k] <= {w_q[k][S-2:0], w_q[k][S-1]};
					r_q[k] <= {r_q[k][S-2:0], nl[k]};
				end
			end
			esf_pkg::CMD_ROW_BWD: begin
				for (int k = 1; k < S; k++) begin
					w_q[k] <= w_q[k-1];
				end
				for (int k = 1; k < S-1; k++) begin
					r_q[k] <= r_q[k-1];
				end
				w_q[0] <= w_q[S-1];
				r_q[0] <= r_q[S-1];
				r_q[S-1] <= nl;
			end
			esf_pkg::CMD_ROW_FWD: begin
				for (int k = 0; k < S-1; k++) begin
					w_q[k] <= w_q[k+1];
					r_q[k] <= r_q[k+1];
				end
				w_q[S-1] <= w_q[0];
				r_q[S-1] <= nl;
			end
		endcase
	end

	assign enclosed_row = ~w_q[0] & ~r_q[0];

endmodule

// ----- hdl/enclosed_region_sweep_fill.sv -----
// Takes a 64 x 64 occupancy map one row per request, row 0 first, and returns one enclosed-cell
// mask per row once the last row is in. Rows are taken one per cycle while busy is low. After
// the 64th row busy rises while one step seeds the border, then four sweeps of 63 line steps
// each run (one line per cycle through the run-fill adders), then the 64 result rows follow back
// to back with result_valid high, rows in order, last_row on row 63. Results are shown for one
// cycle only and cannot be stalled.
module enclosed_region_sweep_fill (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [esf_pkg::SIDE-1:0]    occupied_row,
	output logic                        result_valid,
	output logic [esf_pkg::IDX_W-1:0]   row_number,
	output logic [esf_pkg::SIDE-1:0]    enclosed_row,
	output logic                        last_row
);

	esf_pkg::ctl_t ctl;

	esf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.ctl          (ctl),
		.result_valid (result_valid),
		.row_number   (row_number),
		.last_row     (last_row)
	);

	esf_datapath u_dp (
		.clk          (clk),
		.ctl          (ctl),
		.occupied_row (occupied_row),
		.enclosed_row (enclosed_row)
	);

endmodule

// ----- hdl/esf_checker.sv -----
module esf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        busy,
	input logic                        result_valid,
	input logic [esf_pkg::IDX_W-1:0]   row_number,
	input logic                        last_row
);

	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result outside busy window");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_row |=> result_valid && row_number == $past(row_number) + 1'b1)
		else $error("result burst broken or out of order");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		last_row |-> result_valid && row_number == esf_pkg::IDX_W'(esf_pkg::SIDE - 1))
		else $error("last row flag on wrong row");

	a_free_after: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_row |=> !busy && !result_valid)
		else $error("block not free after last row");

	a_first_row: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> row_number == '0)
		else $error("burst does not start at row zero");

endmodule

bind enclosed_region_sweep_fill esf_checker u_esf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.busy         (busy),
	.result_valid (result_valid),
	.row_number   (row_number),
	.last_row     (last_row)
);

// ----- bench/tb_enclosed_region_sweep_fill.sv -----
`timescale 1ns / 1ps
module tb_enclosed_region_sweep_fill;

	localparam int LIMIT = 200000;
	localparam int DIRECTED_BOARDS = 5;
	localparam int RANDOM_BOARDS = 1;
	localparam int RING_LO = 20;
	localparam int RING_HI = 40;

	typedef enum logic [2:0] {
		BOARD_FREE,
		BOARD_WALL,
		BOARD_RING,
		BOARD_SNAKE,
		BOARD_CHECKER,
		BOARD_RANDOM
	} board_kind_t;

	typedef struct packed {
		board_kind_t kind;
		logic        typed;
	} plan_row_t;

	typedef struct packed {
		logic [esf_pkg::IDX_W-1:0] row;
		esf_pkg::line_t            mask;
		logic                      last;
	} mask_row_t;

	// typed rows carry an expectation that is obvious from the board itself
	localparam plan_row_t DIRECTED [DIRECTED_BOARDS] = '{
		'{BOARD_FREE,    1'b1},
		'{BOARD_WALL,    1'b1},
		'{BOARD_RING,    1'b1},
		'{BOARD_SNAKE,   1'b0},
		'{BOARD_CHECKER, 1'b0}
	};

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	esf_pkg::line_t            occupied_row;
	logic                      result_valid;
	logic [esf_pkg::IDX_W-1:0] row_number;
	esf_pkg::line_t            enclosed_row;
	logic                      last_row;

	esf_pkg::line_t wall_rows [esf_pkg::SIDE];
	esf_pkg::line_t reach_rows [esf_pkg::SIDE];
	esf_pkg::line_t stim_rows [esf_pkg::SIDE];
	int             rows_loaded = 0;
	mask_row_t      pending_masks [$];
	int             mismatches = 0;
	int             cycles = 0;
	int             idle_pct = 0;

	enclosed_region_sweep_fill u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.occupied_row (occupied_row),
		.result_valid (result_valid),
		.row_number   (row_number),
		.enclosed_row (enclosed_row),
		.last_row     (last_row)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit on_board(input int r, input int c);
		return r >= 0 && r < esf_pkg::SIDE && c >= 0 && c < esf_pkg::SIDE;
	endfunction

	function automatic bit reach_at(input int r, input int c);
		if (!on_board(r, c))
			return 1'b0;
		return reach_rows[r][c];
	endfunction

	function automatic bit free_at(input int r, input int c);
		if (!on_board(r, c))
			return 1'b0;
		return !wall_rows[r][c];
	endfunction

	// (pr,pc) points to the previous line, (ar,ac) steps along the line
	function automatic void spread_cell(input int r, input int c, input int pr, input int pc,
			input int ar, input int ac);
		bit hit;
		hit = reach_at(r + pr - ar, c + pc - ac) || reach_at(r + pr, c + pc) ||
			reach_at(r + pr + ar, c + pc + ac) || reach_at(r - ar, c - ac) ||
			reach_at(r + ar, c + ac);
		if (hit && free_at(r, c))
			reach_rows[r][c] = 1'b1;
	endfunction

	function automatic void sweep_column(input int c, input int pc);
		for (int r = 0; r < esf_pkg::SIDE; r++)
			spread_cell(r, c, 0, pc, 1, 0);
		for (int r = esf_pkg::SIDE - 1; r >= 0; r--)
			spread_cell(r, c, 0, pc, 1, 0);
	endfunction

	function automatic void sweep_row(input int r, input int pr);
		for (int c = 0; c < esf_pkg::SIDE; c++)
			spread_cell(r, c, pr, 0, 0, 1);
		for (int c = esf_pkg::SIDE - 1; c >= 0; c--)
			spread_cell(r, c, pr, 0, 0, 1);
	endfunction

	function automatic void flood_board();
		for (int k = 0; k < esf_pkg::SIDE; k++)
			reach_rows[k] = '0;
		for (int k = 0; k < esf_pkg::SIDE; k++) begin
			if (free_at(k, 0))
				reach_rows[k][0] = 1'b1;
			if (free_at(k, esf_pkg::SIDE - 1))
				reach_rows[k][esf_pkg::SIDE-1] = 1'b1;
			if (free_at(0, k))
				reach_rows[0][k] = 1'b1;
			if (free_at(esf_pkg::SIDE - 1, k))
				reach_rows[esf_pkg::SIDE-1][k] = 1'b1;
		end
		for (int k = 1; k < esf_pkg::SIDE; k++)
			sweep_column(k, -1);
		for (int k = esf_pkg::SIDE - 2; k >= 0; k--)
			sweep_column(k, 1);
		for (int k = esf_pkg::SIDE - 2; k >= 0; k--)
			sweep_row(k, 1);
		for (int k = 1; k < esf_pkg::SIDE; k++)
			sweep_row(k, -1);
	endfunction

	function automatic bit take_row(input esf_pkg::line_t v);
		wall_rows[rows_loaded] = v;
		rows_loaded++;
		if (rows_loaded < esf_pkg::SIDE)
			return 1'b0;
		rows_loaded = 0;
		return 1'b1;
	endfunction

	function automatic void push_predicted();
		mask_row_t m;
		for (int r = 0; r < esf_pkg::SIDE; r++) begin
			m.row = r[esf_pkg::IDX_W-1:0];
			m.mask = ~wall_rows[r] & ~reach_rows[r];
			m.last = (r == esf_pkg::SIDE - 1);
			pending_masks.push_back(m);
		end
	endfunction

	function automatic void push_typed(input board_kind_t kind);
		mask_row_t m;
		for (int r = 0; r < esf_pkg::SIDE; r++) begin
			m.row = r[esf_pkg::IDX_W-1:0];
			m.mask = '0;
			m.last = (r == esf_pkg::SIDE - 1);
			if (kind == BOARD_RING && r > RING_LO && r < RING_HI)
				for (int c = RING_LO + 1; c < RING_HI; c++)
					m.mask[c] = 1'b1;
			pending_masks.push_back(m);
		end
	endfunction

	function automatic void draw_box(input int t, input int l, input int b, input int rt);
		for (int c = l; c <= rt; c++) begin
			stim_rows[t][c] = 1'b1;
			stim_rows[b][c] = 1'b1;
		end
		for (int r = t; r <= b; r++) begin
			stim_rows[r][l] = 1'b1;
			stim_rows[r][rt] = 1'b1;
		end
	endfunction

	function automatic esf_pkg::line_t random_word();
		return {$urandom, $urandom};
	endfunction

	function automatic void make_board(input board_kind_t kind, input bit noisy);
		int t;
		int l;
		int b;
		int rt;
		int off;
		for (int r = 0; r < esf_pkg::SIDE; r++)
			stim_rows[r] = (kind == BOARD_WALL) ? '1 : '0;
		case (kind)
			BOARD_RING: begin
				draw_box(RING_LO, RING_LO, RING_HI, RING_HI);
			end
			BOARD_SNAKE: begin
				// winding corridor, entered from the top through a single gap
				draw_box(2, 1, esf_pkg::SIDE - 3, esf_pkg::SIDE - 2);
				stim_rows[2][30] = 1'b0;
				for (int r = 6; r < esf_pkg::SIDE - 3; r += 4) begin
					for (int c = 1; c < esf_pkg::SIDE - 1; c++)
						stim_rows[r][c] = 1'b1;
					stim_rows[r][((r / 4) % 2) ? esf_pkg::SIDE - 3 : 2] = 1'b0;
				end
			end
			BOARD_CHECKER: begin
				for (int r = 0; r < esf_pkg::SIDE; r++)
					stim_rows[r] = r[0] ? {32{2'b10}} : {32{2'b01}};
			end
			BOARD_RANDOM: begin
				if (noisy) begin
					for (int r = 0; r < esf_pkg::SIDE; r++)
						case ($urandom_range(0, 2))
							0: stim_rows[r] = random_word();
							1: stim_rows[r] = random_word() & random_word();
							default: stim_rows[r] = random_word() | random_word();
						endcase
				end else begin
					if ($urandom_range(0, 1))
						for (int r = 0; r < esf_pkg::SIDE; r++)
							stim_rows[r] = random_word() & random_word() & random_word();
					repeat ($urandom_range(1, 6)) begin
						t = $urandom_range(0, esf_pkg::SIDE - 3);
						b = $urandom_range(t + 2, esf_pkg::SIDE - 1);
						l = $urandom_range(0, esf_pkg::SIDE - 3);
						rt = $urandom_range(l + 2, esf_pkg::SIDE - 1);
						draw_box(t, l, b, rt);
						// sometimes leave a hole in the wall
						if ($urandom_range(0, 3) == 0)
							stim_rows[t][$urandom_range(l, rt)] = 1'b0;
					end
					if ($urandom_range(0, 2) == 0) begin
						off = $urandom_range(0, esf_pkg::SIDE - 1);
						for (int r = 0; r < esf_pkg::SIDE; r++)
							stim_rows[r][(r + off) % esf_pkg::SIDE] = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	task automatic report(input string what, input esf_pkg::line_t got,
			input esf_pkg::line_t want);
		$display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send_row(input esf_pkg::line_t v);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			occupied_row <= random_word();
			@(negedge clk);
		end
		start <= 1'b1;
		occupied_row <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	always @(posedge clk) begin : mask_monitor
		mask_row_t want;
		if (arst_n && result_valid) begin
			if (pending_masks.size() == 0) begin
				report("unrequested row", esf_pkg::line_t'(row_number), '0);
			end else begin
				want = pending_masks.pop_front();
				if (row_number !== want.row)
					report("row_number", esf_pkg::line_t'(row_number),
						esf_pkg::line_t'(want.row));
				if (enclosed_row !== want.mask)
					report("enclosed_row", enclosed_row, want.mask);
				if (last_row !== want.last)
					report("last_row", esf_pkg::line_t'(last_row),
						esf_pkg::line_t'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		plan_row_t plan;
		arst_n = 1'b0;
		start = 1'b0;
		occupied_row = '0;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int n = 0; n < DIRECTED_BOARDS + RANDOM_BOARDS; n++) begin
			plan = (n < DIRECTED_BOARDS) ? DIRECTED[n] : plan_row_t'{BOARD_RANDOM, 1'b0};
			idle_pct = (n < 2) ? 24 : ((n < 4) ? 47 : 0);
			make_board(plan.kind, $urandom_range(0, 1) == 1);
			for (int r = 0; r < esf_pkg::SIDE; r++) begin
				send_row(stim_rows[r]);
				if (take_row(stim_rows[r])) begin
					if (plan.typed) begin
						push_typed(plan.kind);
					end else begin
						flood_board();
						push_predicted();
					end
				end
			end
		end
		start <= 1'b0;

		while (pending_masks.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/esf_pkg.sv
hdl/esf_ctrl.sv
hdl/esf_datapath.sv
hdl/enclosed_region_sweep_fill.sv
hdl/esf_checker.sv
bench/tb_enclosed_region_sweep_fill.sv
